[sv/sacl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared geometry, set row types and helpers for the set-associative
// tag store with lru replacement.
// ----------------------------------------------------------------------------
package sacl_pkg;

  // elaboration-time floor of log2
  function automatic int floor_log2(input int v);
    int n;
    int x;
    n = 0;
    x = v;
    while (x > 1) begin
      x = x >> 1;
      n = n + 1;
    end
    return n;
  endfunction

  localparam int SETS       = 128;
  localparam int WAYS       = 4;
  localparam int LINE_BYTES = 64;

  localparam int ADDR_W    = 32;
  localparam int CNT_W     = 32;
  localparam int OUT_WAY_W = 2;

  localparam int OFF_BITS = floor_log2(LINE_BYTES);
  localparam int IDX_BITS = floor_log2(SETS);
  localparam int TAG_BITS = ADDR_W - OFF_BITS - IDX_BITS;
  localparam int SET_W    = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int AGE_W    = WAY_W;

  localparam logic [SET_W-1:0] IDX_MASK =
    (IDX_BITS == 0) ? '0 : SET_W'((64'd1 << IDX_BITS) - 64'd1);
  localparam logic [AGE_W-1:0] AGE_MRU  = AGE_W'(WAYS - 1);
  localparam logic [CNT_W-1:0] CNT_MAX  = '1;

  // one way of a set row
  typedef struct packed {
    logic                vld;
    logic [TAG_BITS-1:0] tag;
    logic [AGE_W-1:0]    age;
  } entry_t;

  typedef entry_t [WAYS-1:0] row_t;

  localparam int ROW_BITS = $bits(row_t);

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic update;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } status_t;

  function automatic logic [SET_W-1:0] addr_set(input logic [ADDR_W-1:0] a);
    return SET_W'(a >> OFF_BITS) & IDX_MASK;
  endfunction

  function automatic logic [TAG_BITS-1:0] addr_tag(input logic [ADDR_W-1:0] a);
    return TAG_BITS'(a >> (OFF_BITS + IDX_BITS));
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage

[sv/sacl_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_ram
// Generic single write port, single read port ram with registered read.
// ----------------------------------------------------------------------------
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/sacl_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_ctrl
// Sequencer for one access: accept and read the set row, then compare,
// update the row and load the result register.
// ----------------------------------------------------------------------------
module sacl_ctrl import sacl_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [0:0] ST_IDLE   = 1'b0;
  localparam logic [0:0] ST_UPDATE = 1'b1;

  logic [0:0] state_r;
  logic [0:0] state_nxt;

  // handshake and commands
  assign in_stall    = (state_r != ST_IDLE);
  assign cmd.capture = in_valid && (state_r == ST_IDLE);
  assign cmd.update  = (state_r == ST_UPDATE) && status.out_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[sv/sacl_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_dpath
// Set row store, tag compare, victim pick, age update, miss counters and
// the result register.
// ----------------------------------------------------------------------------
module sacl_dpath import sacl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  output status_t              status,
  input  logic [ADDR_W-1:0]    in_address,
  input  logic                 in_mode,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_hit,
  output logic                 out_evicted,
  output logic [OUT_WAY_W-1:0] out_way,
  output logic [CNT_W-1:0]     out_load_misses,
  output logic [CNT_W-1:0]     out_store_misses,
  output logic [CNT_W-1:0]     out_evictions
);

  // transaction held during the lookup
  logic [SET_W-1:0]    set_r;
  logic [TAG_BITS-1:0] tag_r;
  logic                mode_r;
  logic                row_vld_r;
  logic [SETS-1:0]     row_written_r;

  logic [ROW_BITS-1:0] rdata;
  row_t                row_c;
  row_t                row_nxt;
  logic                hit_c;
  logic [WAY_W-1:0]    hit_way_c;
  logic [WAY_W-1:0]    vic_way_c;
  logic                vic_found_c;
  logic [WAY_W-1:0]    sel_way_c;
  logic [AGE_W-1:0]    old_age_c;
  logic                evict_c;

  logic                out_valid_r;
  logic                out_hit_r;
  logic                out_evicted_r;
  logic [OUT_WAY_W-1:0] out_way_r;
  logic [CNT_W-1:0]    load_cnt_r;
  logic [CNT_W-1:0]    store_cnt_r;
  logic [CNT_W-1:0]    evict_cnt_r;

  // set row store
  sacl_ram #(
    .WIDTH (ROW_BITS),
    .DEPTH (SETS)
  ) u_rows (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (set_r),
    .wdata (row_nxt),
    .re    (cmd.capture),
    .raddr (addr_set(in_address)),
    .rdata (rdata)
  );

  // capture the access
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      set_r     <= addr_set(in_address);
      tag_r     <= addr_tag(in_address);
      mode_r    <= in_mode;
      row_vld_r <= row_written_r[addr_set(in_address)];
    end
  end

  // rows never written read as cleared
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_written_r <= '0;
    end else if (cmd.update) begin
      row_written_r[set_r] <= 1'b1;
    end
  end

  assign row_c = row_vld_r ? row_t'(rdata) : row_t'('0);

  // tag compare, lowest matching way wins
  always_comb begin
    hit_c     = 1'b0;
    hit_way_c = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (!hit_c && row_c[i].vld && (row_c[i].tag == tag_r)) begin
        hit_c     = 1'b1;
        hit_way_c = WAY_W'(i);
      end
    end
  end

  // victim: lowest way of age zero, way 0 if none
  always_comb begin
    vic_found_c = 1'b0;
    vic_way_c   = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (!vic_found_c && (row_c[i].age == '0)) begin
        vic_found_c = 1'b1;
        vic_way_c   = WAY_W'(i);
      end
    end
  end

  assign sel_way_c = hit_c ? hit_way_c : vic_way_c;
  assign old_age_c = row_c[sel_way_c].age;
  assign evict_c   = !hit_c && row_c[sel_way_c].vld;

  // lru age update and fill
  always_comb begin
    row_nxt = row_c;
    for (int i = 0; i < WAYS; i++) begin
      if (row_c[i].age > old_age_c) begin
        row_nxt[i].age = row_c[i].age - AGE_W'(1);
      end
    end
    row_nxt[sel_way_c].age = AGE_MRU;
    if (!hit_c) begin
      row_nxt[sel_way_c].vld = 1'b1;
      row_nxt[sel_way_c].tag = tag_r;
    end
  end

  // saturating counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_cnt_r  <= '0;
      store_cnt_r <= '0;
      evict_cnt_r <= '0;
    end else if (cmd.update) begin
      if (!hit_c && mode_r) begin
        store_cnt_r <= sat_inc(store_cnt_r);
      end
      if (!hit_c && !mode_r) begin
        load_cnt_r <= sat_inc(load_cnt_r);
      end
      if (evict_c) begin
        evict_cnt_r <= sat_inc(evict_cnt_r);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.update) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_hit_r     <= hit_c;
      out_evicted_r <= evict_c;
      out_way_r     <= OUT_WAY_W'(sel_way_c);
    end
  end

  assign status.out_free  = !out_valid_r || !out_stall;
  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_evicted      = out_evicted_r;
  assign out_way          = out_way_r;
  assign out_load_misses  = load_cnt_r;
  assign out_store_misses = store_cnt_r;
  assign out_evictions    = evict_cnt_r;

  // checks
  a_update_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |=> out_valid_r)
    else $error("result not presented after update");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_hit_r && out_evicted_r))
    else $error("hit reported with eviction");

  a_load_miss_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.update && !hit_c && !mode_r && (load_cnt_r != CNT_MAX))
      |=> (load_cnt_r == $past(load_cnt_r) + CNT_W'(1)))
    else $error("load miss not counted");

  a_no_update_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !cmd.update)
    else $error("result overwritten while stalled");

endmodule

[sv/set_assoc_cache_lru_tags.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_tags
// Tag store of a set-associative data cache with lru replacement.
// ----------------------------------------------------------------------------
// the access is captured and its set row read at acceptance; the result
//   register loads with the row write-back once it is free; a new access
//   waits until the set row is written back, before the next read
// the input is taken again while an earlier result still waits to be taken;
//   the write-back then waits for the result register to free
// reset: synchronous; per-set row flags clear so every line reads invalid at
//   once (no clearing pass), miss and eviction counters go to zero
module set_assoc_cache_lru_tags import sacl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [ADDR_W-1:0]    in_address,
  input  logic                 in_mode,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_hit,
  output logic                 out_evicted,
  output logic [OUT_WAY_W-1:0] out_way,
  output logic [CNT_W-1:0]     out_load_misses,
  output logic [CNT_W-1:0]     out_store_misses,
  output logic [CNT_W-1:0]     out_evictions
);

  cmd_t    cmd;
  status_t status;

  // sequencer
  sacl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // tag store datapath
  sacl_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_address       (in_address),
    .in_mode          (in_mode),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hit          (out_hit),
    .out_evicted      (out_evicted),
    .out_way          (out_way),
    .out_load_misses  (out_load_misses),
    .out_store_misses (out_store_misses),
    .out_evictions    (out_evictions)
  );

endmodule
